>>> sv/pfbr_pkg.sv
// ----------------------------------------------------------------------------
// pfbr_pkg
// Types, codes and constants shared by the pulse filter / beat rate block.
// ----------------------------------------------------------------------------
package pfbr_pkg;

  localparam int unsigned NTAPS_DEFAULT = 32;
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned DIV_BITS      = 16;
  localparam int unsigned BPM_SCALE     = 60;

  localparam logic [9:0]         RATE_RESET   = 10'd50;
  localparam logic signed [15:0] THRESH_RESET = 16'sd10;
  localparam logic [7:0]         HOLD_RESET   = 8'd25;
  localparam logic [15:0]        INTERVAL_MAX = 16'hFFFF;

  // item operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_RATE   = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_HOLD   = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [4:0]         coeff_index;
    logic signed [15:0] coeff_value;
    logic signed [11:0] sample;
  } pfbr_in_t;

  typedef struct packed {
    logic [15:0] beats_per_minute;
    logic [15:0] interval_samples;
  } pfbr_out_t;

  typedef struct packed {
    logic               is_sample;
    logic               load_ok;
    logic [4:0]         coeff_index;
    logic signed [15:0] coeff_value;
    logic signed [11:0] sample;
  } pfbr_cmd_t;

  typedef struct packed {
    logic [9:0]         sample_rate_hz;
    logic signed [15:0] detect_threshold;
    logic [7:0]         holdoff_samples;
  } pfbr_cfg_t;

  typedef struct packed {
    logic idle;
    logic div_busy;
  } pfbr_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DECIDE,
    ST_DIV,
    ST_OUT
  } pfbr_state_e;

endpackage

>>> sv/pfbr_front.sv
// ----------------------------------------------------------------------------
// pfbr_front
// Accepts items, classifies them and holds them in a short command queue.
// ----------------------------------------------------------------------------
module pfbr_front #(
  parameter int unsigned NTAPS = pfbr_pkg::NTAPS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pfbr_pkg::pfbr_in_t  item_i,
  output logic                cmd_valid_o,
  output pfbr_pkg::pfbr_cmd_t cmd_o,
  input  logic                cmd_ready_i
);
  import pfbr_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  pfbr_cmd_t          slot_q [QDEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  pfbr_cmd_t          cmd_new;
  logic               do_push, do_pop;

  always_comb begin
    cmd_new.is_sample   = (item_i.operation == OP_SAMPLE);
    cmd_new.load_ok     = (32'(item_i.coeff_index) < NTAPS);
    cmd_new.coeff_index = item_i.coeff_index;
    cmd_new.coeff_value = item_i.coeff_value;
    cmd_new.sample      = item_i.sample;
  end

  assign full        = (cnt_q == CNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_new;
    end
  end

endmodule

>>> sv/pfbr_div.sv
// ----------------------------------------------------------------------------
// pfbr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfbr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [15:0] quotient_o
);
  import pfbr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_BITS + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [15:0]      rem_q, quo_q, dvs_q;
  logic [16:0]      trial, diff;
  logic             fits;

  assign trial = {rem_q, quo_q[15]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIV_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[15:0] : trial[15:0];
      quo_q <= {quo_q[14:0], fits};
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/pfbr_back.sv
// ----------------------------------------------------------------------------
// pfbr_back
// Carries out commands: coefficient loads, FIR multiply-accumulate over the
// taps, beat detection, rate division and the result register.
// ----------------------------------------------------------------------------
module pfbr_back #(
  parameter int unsigned NTAPS = pfbr_pkg::NTAPS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfbr_pkg::pfbr_cfg_t  cfg_i,
  input  logic                 cmd_valid_i,
  input  pfbr_pkg::pfbr_cmd_t  cmd_i,
  output logic                 cmd_ready_o,
  input  logic                 pop,
  output logic                 empty,
  output pfbr_pkg::pfbr_out_t  result_o,
  output pfbr_pkg::pfbr_stat_t stat_o
);
  import pfbr_pkg::*;

  localparam int unsigned TAP_W  = (NTAPS > 1) ? $clog2(NTAPS) : 1;
  localparam int unsigned FILL_W = $clog2(NTAPS + 1);
  localparam int unsigned ACC_W  = 28 + $clog2(NTAPS);
  localparam int unsigned CMP_W  = ACC_W + 32;

  pfbr_state_e state_q, state_d;

  // control strobes
  logic coef_we, start_sample, issue, decide, div_start, load_out;

  // storage
  logic signed [15:0] coef_mem [NTAPS];
  logic signed [11:0] dly_mem  [NTAPS];

  logic [TAP_W-1:0]  wp_q, wp_next, rd_addr_q, tap_q;
  logic [FILL_W-1:0] fill_q;
  logic              last_tap, tap_live;

  logic signed [15:0]      coef_rd_q;
  logic signed [11:0]      dly_rd_q, dly_gated;
  logic                    v1_q, live1_q, v2_q;
  logic signed [27:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;

  logic signed [CMP_W-1:0] acc_ext, lim_ext;
  logic signed [30:0]      lim31;
  logic                    above, emit;

  logic [7:0]  hold_q;
  logic [15:0] interval_q, ivl_res_q;

  logic        div_busy, div_done;
  logic [15:0] quotient, dividend;

  pfbr_out_t res_q;
  logic      res_valid_q, slot_free;

  assign wp_next   = (wp_q == TAP_W'(NTAPS - 1)) ? '0 : wp_q + 1'b1;
  assign last_tap  = (tap_q == TAP_W'(NTAPS - 1));
  assign tap_live  = (FILL_W'(tap_q) < fill_q);
  assign slot_free = !res_valid_q || pop;

  // floor(acc / 2^15) > t  <=>  acc > t * 2^15 + 32767
  assign lim31   = {cfg_i.detect_threshold, 15'h7FFF};
  assign acc_ext = CMP_W'(acc_q);
  assign lim_ext = CMP_W'(lim31);
  assign above   = (acc_ext > lim_ext);
  assign emit    = above && (hold_q == '0) && (interval_q != '0);
  assign dividend = 16'(32'(cfg_i.sample_rate_hz) * BPM_SCALE);

  always_comb begin
    state_d      = state_q;
    cmd_ready_o  = 1'b0;
    coef_we      = 1'b0;
    start_sample = 1'b0;
    issue        = 1'b0;
    decide       = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.is_sample) begin
            start_sample = 1'b1;
            state_d      = ST_MAC;
          end else begin
            coef_we = cmd_i.load_ok;
          end
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!v1_q && !v2_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        decide = 1'b1;
        if (emit) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // coefficient and delay line memories
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[TAP_W'(cmd_i.coeff_index)] <= cmd_i.coeff_value;
    end
    coef_rd_q <= coef_mem[tap_q];
  end

  always_ff @(posedge clk_i) begin
    if (start_sample) begin
      dly_mem[wp_next] <= cmd_i.sample;
    end
    dly_rd_q <= dly_mem[rd_addr_q];
  end

  // control state of the filter and detector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      fill_q     <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      hold_q     <= '0;
      interval_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (start_sample) begin
        wp_q <= wp_next;
        if (fill_q != FILL_W'(NTAPS)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (decide) begin
        if (above) begin
          hold_q <= cfg_i.holdoff_samples;
        end else if (hold_q != '0) begin
          hold_q <= hold_q - 1'b1;
        end
        if (above && (hold_q == '0)) begin
          interval_q <= 16'd1;
        end else if (interval_q != INTERVAL_MAX) begin
          interval_q <= interval_q + 1'b1;
        end
      end
      if (load_out) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign dly_gated = live1_q ? dly_rd_q : '0;

  // multiply-accumulate datapath
  always_ff @(posedge clk_i) begin
    if (start_sample) begin
      tap_q     <= '0;
      rd_addr_q <= wp_next;
      acc_q     <= '0;
    end else begin
      if (issue) begin
        tap_q     <= tap_q + 1'b1;
        rd_addr_q <= (rd_addr_q == '0) ? TAP_W'(NTAPS - 1) : rd_addr_q - 1'b1;
      end
      if (v2_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    live1_q <= tap_live;
    prod_q  <= coef_rd_q * dly_gated;
    if (decide) begin
      ivl_res_q <= interval_q;
    end
    if (load_out) begin
      res_q.beats_per_minute <= quotient;
      res_q.interval_samples <= ivl_res_q;
    end
  end

  pfbr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (interval_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign empty    = !res_valid_q;
  assign result_o = res_q;

  always_comb begin
    stat_o.idle     = (state_q == ST_IDLE);
    stat_o.div_busy = div_busy;
  end

endmodule

>>> sv/pulse_filter_beat_rate.sv
// ----------------------------------------------------------------------------
// pulse_filter_beat_rate
// FIR-filtered pulse sensor beat detector reporting interval and beat rate.
// ----------------------------------------------------------------------------
// Usage: items enter through push/full and carry either a coefficient load
// (operation 0) or a sensor sample (operation 1). Results leave through
// empty/pop: while empty is low the oldest result sits on result_o, and pop
// takes it. A sample gives at most one result, only when it declares a beat.
// A two-entry command queue sits behind the input, so items are taken while
// the engine works. The engine writes a load while it stays idle. A sample
// runs through the single shared multiply-accumulate that walks the taps
// one per cycle; a sample that reports a beat then goes through the
// bit-serial divider before its result is loaded. If the result register
// is still held, the engine waits for pop and the queue fills up, which
// then raises full. Configuration is to be written through cfg_we_i/
// cfg_idx_i/cfg_data_i only while idle; the block does not enforce this.
// Reset clears the delay line (through a fill count), the hold-off and
// interval counters and the queues, and restores the register defaults.
// Coefficients hold no reset value and must all be loaded before samples.
// ----------------------------------------------------------------------------
module pulse_filter_beat_rate #(
  parameter int unsigned NTAPS = pfbr_pkg::NTAPS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pfbr_pkg::pfbr_in_t  item_i,
  output logic                empty,
  input  logic                pop,
  output pfbr_pkg::pfbr_out_t result_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import pfbr_pkg::*;

  pfbr_cfg_t  cfg_q;
  pfbr_cmd_t  cmd;
  logic       cmd_valid, cmd_ready;
  pfbr_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate_hz   <= RATE_RESET;
      cfg_q.detect_threshold <= THRESH_RESET;
      cfg_q.holdoff_samples  <= HOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RATE:   cfg_q.sample_rate_hz   <= cfg_data_i[9:0];
        CFG_THRESH: cfg_q.detect_threshold <= signed'(cfg_data_i);
        CFG_HOLD:   cfg_q.holdoff_samples  <= cfg_data_i[7:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  pfbr_front #(
    .NTAPS (NTAPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  pfbr_back #(
    .NTAPS (NTAPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result_o),
    .stat_o      (stat)
  );

`ifndef SYNTHESIS
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("queued command changed while the engine was busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> !$past(stat.idle))
    else $error("result appeared without engine activity");

  a_no_accept_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_busy |-> !cmd_ready)
    else $error("engine took a command while dividing");
`endif

endmodule
